>>> hw/rtl/gwnd_pkg.sv
// shared types, constants and helpers for the weighted neighbor difference sum unit
// no dependencies; imported by every module of the block
`default_nettype none

package gwnd_pkg;

    localparam int DATA_W       = 16;
    localparam int PROD_W       = 2 * DATA_W;
    localparam int SUM_W        = 48;
    localparam int ROW_W        = 7;
    localparam int MAX_COLS_DEF = 64;

    localparam logic [SUM_W-1:0] SUM_MAX       = {SUM_W{1'b1}};
    localparam logic [ROW_W-1:0] ROW_WIDTH_RST = 7'd64;

    // configuration register indexes
    localparam logic REG_ROW_WIDTH = 1'b0;
    localparam logic REG_WEIGHTED  = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] cell_value;
        logic [DATA_W-1:0] down_weight;
        logic [DATA_W-1:0] upper_value;
        logic [DATA_W-1:0] upper_weight;
        logic              use_upper;
        logic              weighted;
        logic [DATA_W-1:0] left_diff;
        logic [DATA_W-1:0] left_weight;
        logic              last_cell;
    } t_chain_pkt;

    function automatic logic [DATA_W-1:0] abs_diff(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gwnd_cell.sv
// one line store cell: holds one column of the previous row and passes transactions on
// depends on gwnd_pkg
`default_nettype none

module gwnd_cell
    import gwnd_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int COL_W    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire t_chain_pkt       i_pkt,
    input  wire logic [COL_W-1:0] i_col,
    output logic                  o_vld,
    output t_chain_pkt            o_pkt,
    output logic [COL_W-1:0]      o_col
);

    localparam logic [COL_W-1:0] IDX = COL_W'(CELL_IDX);

    logic              r_vld;
    t_chain_pkt        r_pkt;
    logic [COL_W-1:0]  r_col;
    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] r_dw;
    logic              hit;
    t_chain_pkt        n_pkt;

    assign hit = i_vld && (i_col == IDX);

    always_comb begin
        n_pkt = i_pkt;
        if (hit) begin
            n_pkt.upper_value  = r_val;
            n_pkt.upper_weight = r_dw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    // read before write of the stored column entry
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pkt <= n_pkt;
            r_col <= i_col;
            if (hit) begin
                r_val <= i_pkt.cell_value;
                r_dw  <= i_pkt.down_weight;
            end
        end
    end

    assign o_vld = r_vld;
    assign o_pkt = r_pkt;
    assign o_col = r_col;

endmodule

`default_nettype wire

>>> hw/rtl/gwnd_front.sv
// input stage: column tracking, left neighbor registers and transaction build
// depends on gwnd_pkg
`default_nettype none

module gwnd_front
    import gwnd_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int COL_W    = $clog2(MAX_COLS)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_accept,
    input  wire logic [DATA_W-1:0] i_cell_value,
    input  wire logic [DATA_W-1:0] i_down_weight,
    input  wire logic [DATA_W-1:0] i_right_weight,
    input  wire logic              i_last_cell,
    input  wire logic [ROW_W-1:0]  i_row_width,
    input  wire logic              i_weighted,
    output logic                   o_vld,
    output t_chain_pkt             o_pkt,
    output logic [COL_W-1:0]       o_col
);

    localparam int WCW = $clog2(MAX_COLS + 1);
    localparam int WW  = (WCW > ROW_W) ? WCW : ROW_W;
    localparam logic [WW-1:0] MAX_W = WW'(MAX_COLS);
    localparam logic [WW-1:0] ONE_W = WW'(1);

    logic [COL_W-1:0]  r_col;
    logic              r_first;
    logic [DATA_W-1:0] r_left_val;
    logic [DATA_W-1:0] r_left_rw;
    logic              r_vld;
    t_chain_pkt        r_pkt;
    logic [COL_W-1:0]  r_pkt_col;

    logic [WW-1:0]     row_ext;
    logic [WW-1:0]     width_eff;
    logic [WW-1:0]     col_ext;
    logic [WW-1:0]     col_cur;
    logic [WW-1:0]     col_inc;
    logic              wrap;
    logic              has_left;
    logic [COL_W-1:0]  n_col;
    logic              n_first;
    t_chain_pkt        n_pkt;

    always_comb begin
        row_ext = WW'(i_row_width);
        if (row_ext == '0) begin
            width_eff = ONE_W;
        end else if (row_ext > MAX_W) begin
            width_eff = MAX_W;
        end else begin
            width_eff = row_ext;
        end
        col_ext  = WW'(r_col);
        col_cur  = (col_ext >= width_eff) ? '0 : col_ext;
        col_inc  = col_cur + ONE_W;
        wrap     = (col_inc >= width_eff);
        has_left = (col_cur != '0);

        if (i_last_cell || wrap) begin
            n_col = '0;
        end else begin
            n_col = col_inc[COL_W-1:0];
        end
        if (i_last_cell) begin
            n_first = 1'b1;
        end else if (wrap) begin
            n_first = 1'b0;
        end else begin
            n_first = r_first;
        end

        n_pkt              = '0;
        n_pkt.cell_value   = i_cell_value;
        n_pkt.down_weight  = i_down_weight;
        n_pkt.use_upper    = !r_first;
        n_pkt.weighted     = i_weighted;
        n_pkt.left_diff    = has_left ? abs_diff(i_cell_value, r_left_val) : '0;
        n_pkt.left_weight  = i_weighted ? r_left_rw : DATA_W'(1);
        n_pkt.last_cell    = i_last_cell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_first    <= 1'b1;
            r_left_val <= '0;
            r_left_rw  <= '0;
            r_vld      <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_accept;
            if (i_accept) begin
                r_col      <= n_col;
                r_first    <= n_first;
                r_left_val <= i_last_cell ? '0 : i_cell_value;
                r_left_rw  <= i_last_cell ? '0 : i_right_weight;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_accept) begin
            r_pkt     <= n_pkt;
            r_pkt_col <= col_cur[COL_W-1:0];
        end
    end

    assign o_vld = r_vld;
    assign o_pkt = r_pkt;
    assign o_col = r_pkt_col;

endmodule

`default_nettype wire

>>> hw/rtl/gwnd_accum.sv
// weighting, saturating accumulation and result register
// depends on gwnd_pkg
`default_nettype none

module gwnd_accum
    import gwnd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_vld,
    input  wire t_chain_pkt  i_pkt,
    input  wire logic        i_stall,
    output logic             o_hold,
    output logic             o_valid,
    output logic [SUM_W-1:0] o_total_cost,
    output logic             o_saturated
);

    logic              r1_vld;
    logic              r1_last;
    logic [PROD_W-1:0] r1_up;
    logic [PROD_W-1:0] r1_left;
    logic              r2_vld;
    logic              r2_last;
    logic [PROD_W:0]   r2_pair;
    logic [SUM_W-1:0]  r_sum;
    logic              r_ovld;
    logic [SUM_W-1:0]  r_total;
    logic              r_sat;

    logic [DATA_W-1:0] up_w;
    logic [DATA_W-1:0] up_diff;
    logic [SUM_W:0]    sum_ext;
    logic [SUM_W-1:0]  sum_sat;
    logic              take_last;

    assign up_w    = (i_pkt.weighted && i_pkt.use_upper) ? i_pkt.upper_weight : DATA_W'(1);
    assign up_diff = i_pkt.use_upper ? abs_diff(i_pkt.cell_value, i_pkt.upper_value) : '0;
    assign sum_ext = {1'b0, r_sum} + (SUM_W + 1)'(r2_pair);
    assign sum_sat = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];

    assign o_hold    = r2_vld && r2_last && r_ovld && i_stall;
    assign take_last = i_en && r2_vld && r2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r_sum  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (i_en) begin
                r1_vld <= i_vld;
                r2_vld <= r1_vld;
                if (r2_vld) begin
                    r_sum <= r2_last ? '0 : sum_sat;
                end
            end
            if (take_last) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_last <= i_pkt.last_cell;
            r1_up   <= up_diff * up_w;
            r1_left <= i_pkt.left_diff * i_pkt.left_weight;
            r2_last <= r1_last;
            r2_pair <= {1'b0, r1_up} + {1'b0, r1_left};
        end
        if (take_last) begin
            r_total <= sum_sat;
            r_sat   <= (sum_sat == SUM_MAX);
        end
    end

    assign o_valid      = r_ovld;
    assign o_total_cost = r_total;
    assign o_saturated  = r_sat;

    a_sum_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r2_vld && !r2_last) |=> (r_sum >= $past(r_sum)))
        else $error("running sum decreased inside a grid");

    a_sum_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_last |=> (r_sum == '0) && r_ovld)
        else $error("grid end did not restart the sum or post a result");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_ovld && !r1_vld && !r2_vld)
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

>>> hw/rtl/grid_weighted_neighbor_diff_sum_unit.sv
// top level of the weighted neighbor difference sum unit
// depends on gwnd_pkg, gwnd_front, gwnd_cell, gwnd_accum
//
// usage:
//   input channel (i_valid / o_stall) takes one grid cell per transaction in
//   row-major order with its value, down weight and right weight; i_last_cell
//   closes the grid.
//   output channel (o_valid / i_stall) gives one transaction per grid: the
//   saturating weighted sum and a flag set when it sits at its maximum.
//   apb port: row_width at 0x0, weighted_mode at 0x4; pready is always high.
// throughput: one cell per clock while o_stall is low, set by the line store chain
//   that moves one cell per cycle with one column entry held in each of its MAX_COLS cells.
// path: the last cell of a grid goes from the input register through the MAX_COLS
//   line store cells, the multiply stage and the pair add stage, and is accumulated
//   into the result register, which raises o_valid.
// reset: the pipeline empties, the sum and column tracking clear, row_width
//   returns to 64 and weighted_mode to 0; line store contents are not cleared
//   since the first row of each grid writes them before any stored value is used.
// stall: a result waits in the output register while cells keep flowing; the
//   whole pipeline and o_stall hold only when a second grid end reaches the
//   accumulator while the first result is still stalled.
`default_nettype none

module grid_weighted_neighbor_diff_sum_unit
    import gwnd_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [DATA_W-1:0] i_cell_value,
    input  wire logic [DATA_W-1:0] i_down_weight,
    input  wire logic [DATA_W-1:0] i_right_weight,
    input  wire logic              i_last_cell,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [SUM_W-1:0]       o_total_cost,
    output logic                   o_saturated,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int COL_W = $clog2(MAX_COLS);

    logic [ROW_W-1:0] r_row_width;
    logic             r_weighted;
    logic             cfg_wr;
    logic             reg_sel;
    logic             en;
    logic             hold;
    logic             accept;

    logic             w_vld [MAX_COLS+1];
    t_chain_pkt       w_pkt [MAX_COLS+1];
    logic [COL_W-1:0] w_col [MAX_COLS+1];

    // apb register file
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RST;
            r_weighted  <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_ROW_WIDTH: r_row_width <= pwdata[ROW_W-1:0];
                REG_WEIGHTED:  r_weighted  <= pwdata[0];
                default:       r_weighted  <= r_weighted;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_ROW_WIDTH: prdata = {{(32-ROW_W){1'b0}}, r_row_width};
            REG_WEIGHTED:  prdata = {31'd0, r_weighted};
            default:       prdata = '0;
        endcase
    end

    assign en      = !hold;
    assign o_stall = hold;
    assign accept  = i_valid && en;

    gwnd_front #(
        .MAX_COLS (MAX_COLS),
        .COL_W    (COL_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_accept       (accept),
        .i_cell_value   (i_cell_value),
        .i_down_weight  (i_down_weight),
        .i_right_weight (i_right_weight),
        .i_last_cell    (i_last_cell),
        .i_row_width    (r_row_width),
        .i_weighted     (r_weighted),
        .o_vld          (w_vld[0]),
        .o_pkt          (w_pkt[0]),
        .o_col          (w_col[0])
    );

    for (genvar g = 0; g < MAX_COLS; g++) begin : g_cell
        gwnd_cell #(
            .CELL_IDX (g),
            .COL_W    (COL_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (w_vld[g]),
            .i_pkt   (w_pkt[g]),
            .i_col   (w_col[g]),
            .o_vld   (w_vld[g+1]),
            .o_pkt   (w_pkt[g+1]),
            .o_col   (w_col[g+1])
        );
    end

    gwnd_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_vld        (w_vld[MAX_COLS]),
        .i_pkt        (w_pkt[MAX_COLS]),
        .i_stall      (i_stall),
        .o_hold       (hold),
        .o_valid      (o_valid),
        .o_total_cost (o_total_cost),
        .o_saturated  (o_saturated)
    );

endmodule

`default_nettype wire
